FILE: design/cbe_pkg.sv
package cbe_pkg;

    // Datapath width of the Horner accumulators and coefficients.
    localparam int CW         = 26;
    localparam int QF         = 16;
    localparam int ONE_Q      = 65536;
    localparam int Y_LIM      = 262144;
    localparam int ROUND_HALF = 32768;
    localparam int QW         = 18;
    localparam int NW         = CW + QF;
    localparam int CHAIN_LEN  = 3;

    localparam logic [1:0] CFG_X1 = 2'd0;
    localparam logic [1:0] CFG_Y1 = 2'd1;
    localparam logic [1:0] CFG_X2 = 2'd2;
    localparam logic [1:0] CFG_Y2 = 2'd3;

    typedef enum logic [1:0] {
        MODE_CURVE_X,
        MODE_SLOPE_X,
        MODE_CURVE_Y
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NX_ISSUE,
        ST_NX_SLOPE,
        ST_NX_WAIT,
        ST_DIV,
        ST_BS_ISSUE,
        ST_BS_WAIT,
        ST_Y_ISSUE,
        ST_Y_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                 valid;
        mode_t                mode;
        logic [16:0]          t;
        logic signed [CW-1:0] acc;
    } lane_t;

    typedef struct packed {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] ax3;
        logic signed [CW-1:0] bx2;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] by;
        logic signed [CW-1:0] cy;
    } coef_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic ovf;
    } div_status_t;

    function automatic logic [16:0] sat_x(input logic [16:0] v);
        if (v > 17'(ONE_Q))
            return 17'(ONE_Q);
        return v;
    endfunction

    function automatic logic signed [19:0] sat_y(input logic [19:0] v);
        logic signed [19:0] sv;
        sv = signed'(v);
        if (sv < -Y_LIM)
            return 20'(-Y_LIM);
        if (sv > Y_LIM)
            return 20'(Y_LIM);
        return sv;
    endfunction

    function automatic logic signed [19:0] clamp_y(input logic signed [CW-1:0] v);
        if (v < -Y_LIM)
            return 20'(-Y_LIM);
        if (v > Y_LIM)
            return 20'(Y_LIM);
        return v[19:0];
    endfunction

    // Value that enters the first cell's accumulator.
    function automatic logic signed [CW-1:0] issue_acc(input mode_t m, input coef_t c);
        case (m)
            MODE_CURVE_X: return c.ax;
            MODE_CURVE_Y: return c.ay;
            default:      return '0;
        endcase
    endfunction

    // Coefficient that cell k adds after its multiply, for a given evaluation.
    function automatic logic signed [CW-1:0] cell_coef(input int k, input mode_t m,
                                                       input coef_t c);
        logic signed [CW-1:0] r;
        r = '0;
        case (k)
            0: begin
                case (m)
                    MODE_CURVE_X: r = c.bx;
                    MODE_SLOPE_X: r = c.ax3;
                    MODE_CURVE_Y: r = c.by;
                    default:      r = '0;
                endcase
            end
            1: begin
                case (m)
                    MODE_CURVE_X: r = c.cx;
                    MODE_SLOPE_X: r = c.bx2;
                    MODE_CURVE_Y: r = c.cy;
                    default:      r = '0;
                endcase
            end
            default: begin
                if (m == MODE_SLOPE_X)
                    r = c.cx;
                else
                    r = '0;
            end
        endcase
        return r;
    endfunction

endpackage

FILE: design/cbe_cell.sv
module cbe_cell
    import cbe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lane_t                lane_in,
    input  logic signed [CW-1:0] coef,
    output lane_t                lane_out
);

    localparam int PW = CW + 18;

    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] rnd;
    logic signed [CW-1:0] acc_next;
    logic                 valid_reg;
    mode_t                mode_reg;
    logic [16:0]          t_reg;
    logic signed [CW-1:0] acc_reg;

    // Product rounded to nearest, halves upward, then the next coefficient.
    always_comb
    begin
        prod     = lane_in.acc * $signed({1'b0, lane_in.t});
        rnd      = prod + PW'(ROUND_HALF);
        acc_next = CW'(rnd >>> QF) + coef;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= lane_in.valid;
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= lane_in.mode;
        t_reg    <= lane_in.t;
        acc_reg  <= acc_next;
    end

    assign lane_out.valid = valid_reg;
    assign lane_out.mode  = mode_reg;
    assign lane_out.t     = t_reg;
    assign lane_out.acc   = acc_reg;

endmodule

FILE: design/cbe_div.sv
module cbe_div
    import cbe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NW-1:0]     num,
    input  logic [CW-1:0]     den,
    output logic [QW-1:0]     quot,
    output div_status_t       status
);

    localparam int SW  = CW + QW - 1;
    localparam int CNW = $clog2(QW + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             ovf_reg, ovf_next;
    logic [CNW-1:0]   cnt_reg, cnt_next;
    logic [NW-1:0]    rem_reg, rem_next;
    logic [SW-1:0]    dsh_reg, dsh_next;
    logic [QW-1:0]    q_reg, q_next;
    logic             ge;

    // One quotient bit per cycle, most significant first; a quotient that
    // needs more than QW bits is flagged at the start instead.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        ge        = SW'(rem_reg) >= dsh_reg;
        if (start)
        begin
            ovf_next  = (SW + 1)'(num) >= {den, {QW{1'b0}}};
            rem_next  = num;
            dsh_next  = {den, {(QW - 1){1'b0}}};
            q_next    = '0;
            cnt_next  = CNW'(QW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (ge)
                rem_next = rem_reg - NW'(dsh_reg);
            q_next   = {q_reg[QW-2:0], ge};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - CNW'(1);
            if (cnt_reg == CNW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ovf_reg <= ovf_next;
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign quot        = q_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign status.ovf  = ovf_reg;

endmodule

FILE: design/cubic_bezier_easing_top.sv
// Channel   Direction  Ports                     Item
// s_*       in         s_tvalid/s_tready/s_tdata progress
// m_*       out        m_tvalid/m_tready/m_tdata eased_value
// cfg_*     in         cfg_we/cfg_idx/cfg_data   control point write
//
// One item at a time. Each polynomial evaluation passes a chain of three
// multiply-add cells; a Newton step takes two evaluations and a division,
// and a bisection probe takes one evaluation. Reset restores the default
// control points; the coefficients are registered from them after any
// write. A result waiting on m_tready lets the next item start; that item
// then waits in its last state until the output register frees.
module cubic_bezier_easing_top
    import cbe_pkg::*;
#(
    parameter int NEWTON_STEPS = 8,
    parameter int FRAC_BITS    = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [16:0] progress
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [19:0] eased_value
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [19:0] cfg_data
);

    localparam int NCW = $clog2(NEWTON_STEPS + 2);
    localparam int FCW = $clog2(FRAC_BITS + 1);

    logic [16:0]        x1_reg, x2_reg;
    logic signed [19:0] y1_reg, y2_reg;
    coef_t              coef_reg, coef_next;

    state_t             state_reg, state_next;
    logic [16:0]        t_reg, t_next;
    logic [16:0]        x_reg, x_next;
    logic [16:0]        lo_reg, lo_next;
    logic [16:0]        hi_reg, hi_next;
    logic signed [CW-1:0] e_reg, e_next;
    logic               d_neg_reg, d_neg_next;
    logic [NCW-1:0]     n_cnt_reg, n_cnt_next;
    logic [FCW-1:0]     b_cnt_reg, b_cnt_next;
    logic signed [19:0] res_reg, res_next;
    logic               out_valid_reg, out_valid_next;
    logic [19:0]        out_data_reg, out_data_next;

    lane_t              lane [0:CHAIN_LEN];
    lane_t              issue;
    lane_t              chain_out;

    logic               accept;
    logic signed [CW-1:0] x_s, v, e_now;
    logic               e_small, d_small, cx_got, sl_got, y_got;
    logic               newton_last, bs_more, x_gt_v, out_load;
    logic               div_start, sign_pos;
    logic [CW-1:0]      e_abs, d_abs;
    logic [QW-1:0]      quot;
    div_status_t        div_st;
    logic signed [19:0] q_s, tt;
    logic [16:0]        t_newton;
    logic [16:0]        lo_bs, hi_bs;

    // Control point registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg <= 17'd16384;
            y1_reg <= 20'sd0;
            x2_reg <= 17'd49152;
            y2_reg <= 20'sd65536;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_X1:  x1_reg <= sat_x(cfg_data[16:0]);
                CFG_Y1:  y1_reg <= sat_y(cfg_data);
                CFG_X2:  x2_reg <= sat_x(cfg_data[16:0]);
                CFG_Y2:  y2_reg <= sat_y(cfg_data);
                default: ;
            endcase
        end
    end

    always_comb
    begin
        logic signed [CW-1:0] x1s, x2s, y1s, y2s, dx, dy;
        x1s = CW'(x1_reg);
        x2s = CW'(x2_reg);
        y1s = CW'(y1_reg);
        y2s = CW'(y2_reg);
        x1s = $signed({9'b0, x1_reg});
        x2s = $signed({9'b0, x2_reg});
        dx  = x2s - x1s;
        dy  = y2s - y1s;
        coef_next.cx  = x1s + (x1s <<< 1);
        coef_next.bx  = dx + (dx <<< 1) - coef_next.cx;
        coef_next.ax  = CW'(ONE_Q) - coef_next.cx - coef_next.bx;
        coef_next.ax3 = coef_next.ax + (coef_next.ax <<< 1);
        coef_next.bx2 = coef_next.bx <<< 1;
        coef_next.cy  = y1s + (y1s <<< 1);
        coef_next.by  = dy + (dy <<< 1) - coef_next.cy;
        coef_next.ay  = CW'(ONE_Q) - coef_next.cy - coef_next.by;
    end

    always_ff @(posedge clk)
    begin
        coef_reg <= coef_next;
    end

    // Horner chain: each cell multiplies by t and adds its coefficient.
    assign lane[0] = issue;

    for (genvar k = 0; k < CHAIN_LEN; k++)
    begin : g_cell
        cbe_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .lane_in  (lane[k]),
            .coef     (cell_coef(k, lane[k].mode, coef_reg)),
            .lane_out (lane[k+1])
        );
    end

    assign chain_out = lane[CHAIN_LEN];

    cbe_div u_div
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    ({e_abs, {QF{1'b0}}}),
        .den    (d_abs),
        .quot   (quot),
        .status (div_st)
    );

    // Decision flags.
    always_comb
    begin
        x_s         = $signed({9'b0, x_reg});
        v           = chain_out.acc;
        e_now       = v - x_s;
        e_small     = (e_now >= -1) && (e_now <= 1);
        d_small     = (v >= -1) && (v <= 1);
        cx_got      = chain_out.valid && (chain_out.mode == MODE_CURVE_X);
        sl_got      = chain_out.valid && (chain_out.mode == MODE_SLOPE_X);
        y_got       = chain_out.valid && (chain_out.mode == MODE_CURVE_Y);
        newton_last = (n_cnt_reg == NCW'(NEWTON_STEPS - 1));
        bs_more     = (b_cnt_reg < FCW'(FRAC_BITS)) && (lo_reg < hi_reg);
        x_gt_v      = x_s > v;
        accept      = s_tvalid && s_tready;
        out_load    = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);
        e_abs       = e_reg[CW-1] ? CW'(-e_reg) : CW'(e_reg);
        d_abs       = v[CW-1] ? CW'(-v) : CW'(v);
        sign_pos    = e_reg[CW-1] == d_neg_reg;
        q_s         = sign_pos ? $signed({2'b0, quot}) : -$signed({2'b0, quot});
        tt          = $signed({3'b0, t_reg}) - q_s;
        if (div_st.ovf)
            t_newton = sign_pos ? 17'd0 : 17'(ONE_Q);
        else if (tt < 0)
            t_newton = 17'd0;
        else if (tt > ONE_Q)
            t_newton = 17'(ONE_Q);
        else
            t_newton = tt[16:0];
        lo_bs = x_gt_v ? t_reg : lo_reg;
        hi_bs = x_gt_v ? hi_reg : t_reg;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = (NEWTON_STEPS > 0) ? ST_NX_ISSUE : ST_BS_ISSUE;
            ST_NX_ISSUE:
                state_next = ST_NX_SLOPE;
            ST_NX_SLOPE:
                state_next = ST_NX_WAIT;
            ST_NX_WAIT:
            begin
                if (cx_got && e_small)
                    state_next = ST_Y_ISSUE;
                else if (sl_got)
                    state_next = d_small ? ST_BS_ISSUE : ST_DIV;
            end
            ST_DIV:
                if (div_st.done)
                    state_next = newton_last ? ST_BS_ISSUE : ST_NX_ISSUE;
            ST_BS_ISSUE:
                state_next = bs_more ? ST_BS_WAIT : ST_Y_ISSUE;
            ST_BS_WAIT:
                if (cx_got)
                    state_next = e_small ? ST_Y_ISSUE : ST_BS_ISSUE;
            ST_Y_ISSUE:
                state_next = ST_Y_WAIT;
            ST_Y_WAIT:
                if (y_got)
                    state_next = ST_DONE;
            ST_DONE:
                if (out_load)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        t_next         = t_reg;
        x_next         = x_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        e_next         = e_reg;
        d_neg_next     = d_neg_reg;
        n_cnt_next     = n_cnt_reg;
        b_cnt_next     = b_cnt_reg;
        res_next       = res_reg;
        div_start      = 1'b0;
        issue          = '0;
        issue.mode     = MODE_CURVE_X;
        issue.t        = t_reg;
        issue.acc      = issue_acc(MODE_CURVE_X, coef_reg);
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        if (m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    x_next     = sat_x(s_tdata[16:0]);
                    t_next     = sat_x(s_tdata[16:0]);
                    lo_next    = '0;
                    hi_next    = 17'(ONE_Q);
                    n_cnt_next = '0;
                    b_cnt_next = '0;
                end
            ST_NX_ISSUE:
                issue.valid = 1'b1;
            ST_NX_SLOPE:
            begin
                issue.valid = 1'b1;
                issue.mode  = MODE_SLOPE_X;
                issue.acc   = issue_acc(MODE_SLOPE_X, coef_reg);
            end
            ST_NX_WAIT:
            begin
                if (cx_got)
                    e_next = e_now;
                if (sl_got)
                begin
                    d_neg_next = v[CW-1];
                    if (d_small)
                    begin
                        t_next     = x_reg;
                        lo_next    = '0;
                        hi_next    = 17'(ONE_Q);
                        b_cnt_next = '0;
                    end
                    else
                        div_start = 1'b1;
                end
            end
            ST_DIV:
                if (div_st.done)
                begin
                    n_cnt_next = n_cnt_reg + NCW'(1);
                    if (newton_last)
                    begin
                        t_next     = x_reg;
                        lo_next    = '0;
                        hi_next    = 17'(ONE_Q);
                        b_cnt_next = '0;
                    end
                    else
                        t_next = t_newton;
                end
            ST_BS_ISSUE:
                issue.valid = bs_more;
            ST_BS_WAIT:
                if (cx_got && !e_small)
                begin
                    lo_next    = lo_bs;
                    hi_next    = hi_bs;
                    t_next     = 17'(({1'b0, lo_bs} + {1'b0, hi_bs}) >> 1);
                    b_cnt_next = b_cnt_reg + FCW'(1);
                end
            ST_Y_ISSUE:
            begin
                issue.valid = 1'b1;
                issue.mode  = MODE_CURVE_Y;
                issue.acc   = issue_acc(MODE_CURVE_Y, coef_reg);
            end
            ST_Y_WAIT:
                if (y_got)
                    res_next = clamp_y(v);
            default: ;
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            n_cnt_reg     <= '0;
            b_cnt_reg     <= '0;
            t_reg         <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            n_cnt_reg     <= n_cnt_next;
            b_cnt_reg     <= b_cnt_next;
            t_reg         <= t_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        e_reg        <= e_next;
        d_neg_reg    <= d_neg_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_data_reg};

`ifndef SYNTHESIS
    a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
        t_reg <= 17'(ONE_Q))
        else $error("t outside the unit interval");

    a_bisect_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BS_ISSUE || state_reg == ST_BS_WAIT) |-> lo_reg <= hi_reg)
        else $error("bisection bounds crossed");

    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_st.busy |-> state_reg == ST_DIV)
        else $error("divider busy outside a Newton step");

    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_tvalid && (m_tdata[19:0] == $past(res_reg)))
        else $error("result not presented after completion");
`endif

endmodule
